FILE: rtl/core/hrt_pkg.sv
// shared types, character codes and constants of the request tokenizer
package hrt_pkg;

	// default header limit
	localparam int MAX_HEADERS = 16;

	// beat widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	// characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// byte roles
	localparam logic [2:0] ROLE_DELIM   = 3'd0;
	localparam logic [2:0] ROLE_METHOD  = 3'd1;
	localparam logic [2:0] ROLE_URI     = 3'd2;
	localparam logic [2:0] ROLE_VERSION = 3'd3;
	localparam logic [2:0] ROLE_KEY     = 3'd4;
	localparam logic [2:0] ROLE_VALUE   = 3'd5;

	// verdicts
	localparam logic [1:0] VERD_NONE = 2'd0;
	localparam logic [1:0] VERD_ACC  = 2'd1;
	localparam logic [1:0] VERD_REJ  = 2'd2;

	// byte class handed from the front to the back
	typedef enum logic [2:0] {
		CLS_OTHER = 3'd0,
		CLS_SP    = 3'd1,
		CLS_CR    = 3'd2,
		CLS_LF    = 3'd3,
		CLS_COLON = 3'd4,
		CLS_NUL   = 3'd5
	} byte_class_t;

	// parser phase, one-hot
	typedef enum logic [10:0] {
		PH_METHOD  = 11'b000_0000_0001,
		PH_URI     = 11'b000_0000_0010,
		PH_VERSION = 11'b000_0000_0100,
		PH_LINE_LF = 11'b000_0000_1000,
		PH_HDR_GO  = 11'b000_0001_0000,
		PH_KEY     = 11'b000_0010_0000,
		PH_SKIP_SP = 11'b000_0100_0000,
		PH_VALUE   = 11'b000_1000_0000,
		PH_HDR_LF  = 11'b001_0000_0000,
		PH_END_LF  = 11'b010_0000_0000,
		PH_DONE    = 11'b100_0000_0000
	} phase_t;

	// one result beat
	typedef struct packed {
		logic [1:0] verdict;
		logic [4:0] header_count;
		logic [3:0] header_index;
		logic [2:0] byte_role;
	} result_t;

endpackage

FILE: rtl/core/hrt_classify.sv
// front stage: takes input beats and reduces each byte to its class
module hrt_classify (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               in_byte,
	output logic                     push,
	input  logic                     push_ready,
	output hrt_pkg::byte_class_t     push_class
);

	logic                 v_s1;
	hrt_pkg::byte_class_t cls_s1;
	hrt_pkg::byte_class_t cls_d;

	always_comb begin
		case (in_byte)
			hrt_pkg::CH_NUL:   cls_d = hrt_pkg::CLS_NUL;
			hrt_pkg::CH_SP:    cls_d = hrt_pkg::CLS_SP;
			hrt_pkg::CH_CR:    cls_d = hrt_pkg::CLS_CR;
			hrt_pkg::CH_LF:    cls_d = hrt_pkg::CLS_LF;
			hrt_pkg::CH_COLON: cls_d = hrt_pkg::CLS_COLON;
			default:           cls_d = hrt_pkg::CLS_OTHER;
		endcase
	end

	assign in_ready   = !v_s1 || push_ready;
	assign push       = v_s1;
	assign push_class = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

FILE: rtl/core/hrt_queue.sv
// two-entry queue of byte classes between front and back
module hrt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 push_ready,
	input  hrt_pkg::byte_class_t push_class,
	output logic                 pop_valid,
	input  logic                 pop,
	output hrt_pkg::byte_class_t pop_class
);

	hrt_pkg::byte_class_t mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_class  = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_class;
		end
	end

endmodule

FILE: rtl/core/hrt_parse.sv
// back stage: request grammar state machine with registered result
module hrt_parse #(
	parameter int MaxHeaders = hrt_pkg::MAX_HEADERS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop,
	input  hrt_pkg::byte_class_t pop_class,
	output logic                 res_valid,
	input  logic                 res_ready,
	output hrt_pkg::result_t     res
);

	localparam int CntW = $clog2(MaxHeaders + 1);

	hrt_pkg::phase_t  phase_q;
	hrt_pkg::phase_t  phase_d;
	logic [CntW-1:0]  hdr_cnt_q;
	logic [CntW-1:0]  hdr_cnt_d;
	logic             rej_q;
	logic             rej_d;
	logic             out_v_q;
	hrt_pkg::result_t res_q;
	hrt_pkg::result_t res_d;
	logic [2:0]       role;
	logic             use_idx;
	logic [1:0]       verdict;
	logic [CntW-1:0]  count_src;
	logic [CntW+4:0]  idx_ext;
	logic [CntW+4:0]  cnt_ext;

	assign pop = pop_valid && (!out_v_q || res_ready);

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		rej_d     = rej_q;
		role      = hrt_pkg::ROLE_DELIM;
		use_idx   = 1'b0;
		verdict   = hrt_pkg::VERD_NONE;
		count_src = hdr_cnt_q;
		if (pop_class == hrt_pkg::CLS_NUL) begin
			// terminator: give verdict, count before the reset
			verdict   = (phase_q == hrt_pkg::PH_DONE && !rej_q) ?
				hrt_pkg::VERD_ACC : hrt_pkg::VERD_REJ;
			phase_d   = hrt_pkg::PH_METHOD;
			hdr_cnt_d = '0;
			rej_d     = 1'b0;
		end else begin
			case (phase_q)
				hrt_pkg::PH_METHOD: begin
					if (pop_class == hrt_pkg::CLS_SP) phase_d = hrt_pkg::PH_URI;
					else role = hrt_pkg::ROLE_METHOD;
				end
				hrt_pkg::PH_URI: begin
					if (pop_class == hrt_pkg::CLS_SP) phase_d = hrt_pkg::PH_VERSION;
					else role = hrt_pkg::ROLE_URI;
				end
				hrt_pkg::PH_VERSION: begin
					if (pop_class == hrt_pkg::CLS_CR) phase_d = hrt_pkg::PH_LINE_LF;
					else role = hrt_pkg::ROLE_VERSION;
				end
				hrt_pkg::PH_LINE_LF: begin
					if (pop_class == hrt_pkg::CLS_LF) phase_d = hrt_pkg::PH_HDR_GO;
				end
				hrt_pkg::PH_HDR_GO, hrt_pkg::PH_KEY: begin
					if (phase_q == hrt_pkg::PH_HDR_GO && pop_class == hrt_pkg::CLS_CR) begin
						phase_d = hrt_pkg::PH_END_LF;
					end else if (pop_class == hrt_pkg::CLS_COLON) begin
						phase_d = hrt_pkg::PH_SKIP_SP;
					end else begin
						phase_d = hrt_pkg::PH_KEY;
						role    = hrt_pkg::ROLE_KEY;
						use_idx = 1'b1;
					end
				end
				hrt_pkg::PH_SKIP_SP: begin
					if (pop_class == hrt_pkg::CLS_SP) phase_d = hrt_pkg::PH_VALUE;
				end
				hrt_pkg::PH_VALUE: begin
					if (pop_class == hrt_pkg::CLS_CR) begin
						phase_d = hrt_pkg::PH_HDR_LF;
					end else begin
						role    = hrt_pkg::ROLE_VALUE;
						use_idx = 1'b1;
					end
				end
				hrt_pkg::PH_HDR_LF: begin
					if (pop_class == hrt_pkg::CLS_LF) begin
						// header complete; one past the limit rejects
						if (hdr_cnt_q >= CntW'(MaxHeaders)) begin
							rej_d   = 1'b1;
							phase_d = hrt_pkg::PH_DONE;
						end else begin
							hdr_cnt_d = hdr_cnt_q + CntW'(1);
							phase_d   = hrt_pkg::PH_HDR_GO;
						end
					end
				end
				hrt_pkg::PH_END_LF: begin
					if (pop_class == hrt_pkg::CLS_LF) phase_d = hrt_pkg::PH_DONE;
				end
				default: begin
					phase_d = hrt_pkg::PH_DONE;
				end
			endcase
			count_src = hdr_cnt_d;
		end
	end

	assign idx_ext = {5'd0, hdr_cnt_q};
	assign cnt_ext = {5'd0, count_src};

	always_comb begin
		res_d.byte_role    = role;
		res_d.header_index = use_idx ? idx_ext[3:0] : 4'd0;
		res_d.header_count = cnt_ext[4:0];
		res_d.verdict      = verdict;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= hrt_pkg::PH_METHOD;
			hdr_cnt_q <= '0;
			rej_q     <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (pop) begin
				phase_q   <= phase_d;
				hdr_cnt_q <= hdr_cnt_d;
				rej_q     <= rej_d;
				out_v_q   <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign res_valid = out_v_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("parser phase not one-hot");

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= CntW'(MaxHeaders))
		else $error("header count beyond limit");

	a_rej_done: assert property (@(posedge clk) disable iff (!arst_n)
		rej_q |-> phase_q == hrt_pkg::PH_DONE)
		else $error("reject flag outside done phase");

	a_term_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_class == hrt_pkg::CLS_NUL) |=>
		(phase_q == hrt_pkg::PH_METHOD && hdr_cnt_q == '0 && !rej_q &&
		res_q.verdict != hrt_pkg::VERD_NONE))
		else $error("terminator did not reset parser");
`endif

endmodule

FILE: rtl/core/http_request_tokenizer.sv
// top level of the request tokenizer: classify front, class queue, parser back
// path: an accepted byte passes the front class register, a queue entry and the parser output register
// throughput: one byte per cycle sustained while m_tready stays high; the two-entry queue
// and the output register let input and output stall independently
// reset: arst_n clears all valid flags, the queue and the parser state at once;
// the parser starts in the method phase with zero headers and no reject
module http_request_tokenizer #(
	parameter int MaxHeaders = hrt_pkg::MAX_HEADERS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input beats
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [hrt_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] data_byte
	// result beats
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [hrt_pkg::OUT_DATA_W-1:0] m_tdata   // [2:0] byte_role, [6:3] header_index,
	                                                 // [11:7] header_count, [13:12] verdict,
	                                                 // [15:14] zero
);

	// front to queue
	logic                 push;
	logic                 push_ready;
	hrt_pkg::byte_class_t push_class;
	// queue to back
	logic                 pop_valid;
	logic                 pop;
	hrt_pkg::byte_class_t pop_class;
	// back result
	hrt_pkg::result_t     res;

	// front: one register stage holding the class of each accepted byte
	hrt_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.push       (push),
		.push_ready (push_ready),
		.push_class (push_class)
	);

	// decoupling queue, full rate with simultaneous push and pop
	hrt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_class (push_class),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_class  (pop_class)
	);

	// back: grammar state machine, one class per cycle into the output register while the result side is ready
	hrt_parse #(
		.MaxHeaders (MaxHeaders)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_class (pop_class),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack result fields, lowest field first, zero fill to whole bytes
	assign m_tdata = {2'b00, res};

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// testbench of the http request tokenizer: directed and random requests checked beat by beat
module tb;

	localparam int STALL_LIMIT   = 1000;	// cycles with no beat on either side
	localparam int SETTLE_CYCLES = 8;	// margin after the last result beat
	localparam int RANDOM_BYTES  = 200;	// per idling mode

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	// tokenizer state as predicted from the accepted bytes
	hrt_pkg::phase_t  model_phase;
	logic [4:0]       model_headers;
	logic             model_rejected;

	hrt_pkg::result_t expected_results[$];
	logic [7:0]       request_bytes[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;
	int bytes_sent    = 0;
	int accept_seen   = 0;
	int reject_seen   = 0;
	int stall_cycles  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	http_request_tokenizer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// advance the predicted tokenizer by one byte and return the beat it should emit
	function automatic hrt_pkg::result_t tokenize_byte(input logic [7:0] b);
		hrt_pkg::result_t r;
		r = '0;
		r.byte_role = hrt_pkg::ROLE_DELIM;
		r.verdict = hrt_pkg::VERD_NONE;
		if (b == hrt_pkg::CH_NUL) begin
			// terminator: count before the clear, verdict, then back to reset state
			r.header_count = model_headers;
			r.verdict = (model_phase == hrt_pkg::PH_DONE && !model_rejected) ?
				hrt_pkg::VERD_ACC : hrt_pkg::VERD_REJ;
			model_phase = hrt_pkg::PH_METHOD;
			model_headers = '0;
			model_rejected = 1'b0;
		end else begin
			case (model_phase)
				hrt_pkg::PH_METHOD: begin
					if (b == hrt_pkg::CH_SP) model_phase = hrt_pkg::PH_URI;
					else r.byte_role = hrt_pkg::ROLE_METHOD;
				end
				hrt_pkg::PH_URI: begin
					if (b == hrt_pkg::CH_SP) model_phase = hrt_pkg::PH_VERSION;
					else r.byte_role = hrt_pkg::ROLE_URI;
				end
				hrt_pkg::PH_VERSION: begin
					if (b == hrt_pkg::CH_CR) model_phase = hrt_pkg::PH_LINE_LF;
					else r.byte_role = hrt_pkg::ROLE_VERSION;
				end
				hrt_pkg::PH_LINE_LF: begin
					if (b == hrt_pkg::CH_LF) model_phase = hrt_pkg::PH_HDR_GO;
				end
				hrt_pkg::PH_HDR_GO, hrt_pkg::PH_KEY: begin
					// cr only ends the headers at the start of a line
					if (model_phase == hrt_pkg::PH_HDR_GO && b == hrt_pkg::CH_CR) begin
						model_phase = hrt_pkg::PH_END_LF;
					end else if (b == hrt_pkg::CH_COLON) begin
						model_phase = hrt_pkg::PH_SKIP_SP;
					end else begin
						model_phase = hrt_pkg::PH_KEY;
						r.byte_role = hrt_pkg::ROLE_KEY;
						r.header_index = model_headers[3:0];
					end
				end
				hrt_pkg::PH_SKIP_SP: begin
					if (b == hrt_pkg::CH_SP) model_phase = hrt_pkg::PH_VALUE;
				end
				hrt_pkg::PH_VALUE: begin
					if (b == hrt_pkg::CH_CR) begin
						model_phase = hrt_pkg::PH_HDR_LF;
					end else begin
						r.byte_role = hrt_pkg::ROLE_VALUE;
						r.header_index = model_headers[3:0];
					end
				end
				hrt_pkg::PH_HDR_LF: begin
					if (b == hrt_pkg::CH_LF) begin
						// a header past the limit rejects, count stays at the limit
						if (model_headers >= hrt_pkg::MAX_HEADERS) begin
							model_rejected = 1'b1;
							model_phase = hrt_pkg::PH_DONE;
						end else begin
							model_headers = model_headers + 5'd1;
							model_phase = hrt_pkg::PH_HDR_GO;
						end
					end
				end
				hrt_pkg::PH_END_LF: begin
					if (b == hrt_pkg::CH_LF) model_phase = hrt_pkg::PH_DONE;
				end
				default: begin
					model_phase = hrt_pkg::PH_DONE;
				end
			endcase
			r.header_count = model_headers;
		end
		return r;
	endfunction

	// random token byte that none of the phases treats specially
	function automatic logic [7:0] pick_plain();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255, 1));
		while (b == hrt_pkg::CH_SP || b == hrt_pkg::CH_CR || b == hrt_pkg::CH_LF ||
			b == hrt_pkg::CH_COLON);
		return b;
	endfunction

	function automatic logic [7:0] pick_other_than(input logic [7:0] stop);
		logic [7:0] b;
		do
			b = 8'($urandom_range(255, 1));
		while (b == stop);
		return b;
	endfunction

	function automatic logic [7:0] pick_delim();
		case ($urandom_range(3))
			0: return hrt_pkg::CH_SP;
			1: return hrt_pkg::CH_CR;
			2: return hrt_pkg::CH_LF;
			default: return hrt_pkg::CH_COLON;
		endcase
	endfunction

	function automatic void push_token(input int max_len);
		repeat ($urandom_range(max_len, 0)) request_bytes.push_back(pick_plain());
	endfunction

	// sometimes a stray byte in a phase that skips up to the given delimiter
	function automatic void push_skipped(input logic [7:0] stop);
		if ($urandom_range(3) == 0) request_bytes.push_back(pick_other_than(stop));
		request_bytes.push_back(stop);
	endfunction

	// one random request: mostly well formed, some cut short, some plain noise
	function automatic void build_request();
		int kind;
		int n_headers;
		int cut;
		request_bytes.delete();
		kind = $urandom_range(99);
		if (kind < 10) begin
			repeat ($urandom_range(12)) begin
				if ($urandom_range(2) == 0) request_bytes.push_back(pick_delim());
				else request_bytes.push_back(8'($urandom_range(255, 1)));
			end
		end else begin
			case ($urandom_range(99)) inside
				[0:74]:  n_headers = $urandom_range(2);
				[75:94]: n_headers = $urandom_range(8, 3);
				default: n_headers = $urandom_range(hrt_pkg::MAX_HEADERS + 2,
					hrt_pkg::MAX_HEADERS - 1);
			endcase
			push_token(3);
			request_bytes.push_back(hrt_pkg::CH_SP);
			push_token(3);
			request_bytes.push_back(hrt_pkg::CH_SP);
			push_token(2);
			request_bytes.push_back(hrt_pkg::CH_CR);
			push_skipped(hrt_pkg::CH_LF);
			repeat (n_headers) begin
				push_token(2);
				request_bytes.push_back(hrt_pkg::CH_COLON);
				push_skipped(hrt_pkg::CH_SP);
				push_token(3);
				request_bytes.push_back(hrt_pkg::CH_CR);
				push_skipped(hrt_pkg::CH_LF);
			end
			request_bytes.push_back(hrt_pkg::CH_CR);
			push_skipped(hrt_pkg::CH_LF);
			// bytes after the end of the headers are ignored
			repeat ($urandom_range(2)) request_bytes.push_back(8'($urandom_range(255, 1)));
			if (kind < 35) begin
				cut = $urandom_range(request_bytes.size() - 1, 0);
				while (request_bytes.size() > cut) void'(request_bytes.pop_back());
			end
		end
		request_bytes.push_back(hrt_pkg::CH_NUL);
	endfunction

	// one input beat; valid stays high into the next byte unless the sender idles
	task automatic send_byte(input logic [7:0] b);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_results.push_back(tokenize_byte(b));
		bytes_sent++;
	endtask

	task automatic send_request(input logic [7:0] seq[$]);
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	// terminator alone, byte extremes, empty key, trailing bytes after the accept
	task automatic test_directed_requests();
		logic [7:0] seq[$];
		seq = '{hrt_pkg::CH_NUL,
			8'hFF, hrt_pkg::CH_SP, 8'h01, hrt_pkg::CH_SP, 8'h7F, hrt_pkg::CH_CR,
			hrt_pkg::CH_LF,
			8'h6B, hrt_pkg::CH_COLON, 8'h80, hrt_pkg::CH_SP, 8'h76, hrt_pkg::CH_CR,
			hrt_pkg::CH_LF,
			hrt_pkg::CH_COLON, hrt_pkg::CH_SP, hrt_pkg::CH_CR, hrt_pkg::CH_LF,
			hrt_pkg::CH_CR, hrt_pkg::CH_LF, 8'h58, hrt_pkg::CH_NUL};
		send_request(seq);
	endtask

	// one header more than the limit, header index wraps on the last key
	task automatic test_header_limit();
		logic [7:0] seq[$];
		seq = '{hrt_pkg::CH_SP, hrt_pkg::CH_SP, hrt_pkg::CH_CR, hrt_pkg::CH_LF};
		repeat (hrt_pkg::MAX_HEADERS + 1) begin
			seq.push_back(8'h6B);
			seq.push_back(hrt_pkg::CH_COLON);
			seq.push_back(hrt_pkg::CH_SP);
			seq.push_back(8'h76);
			seq.push_back(hrt_pkg::CH_CR);
			seq.push_back(hrt_pkg::CH_LF);
		end
		seq.push_back(hrt_pkg::CH_CR);
		seq.push_back(hrt_pkg::CH_NUL);
		send_request(seq);
	endtask

	task automatic test_random_requests(input int byte_budget);
		int start;
		bit paused;
		start = bytes_sent;
		paused = 1'b0;
		while (bytes_sent - start < byte_budget) begin
			build_request();
			send_request(request_bytes);
			if (!paused && bytes_sent - start > byte_budget / 2) begin
				pause_until_drained();
				paused = 1'b1;
			end
		end
	endtask

	// result side: random ready, beat check against the oldest prediction, stall watchdog
	always @(posedge clk) begin : result_check
		hrt_pkg::result_t got;
		hrt_pkg::result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[13:0];
				if (expected_results.size() == 0) begin
					$error("unexpected result beat 0x%04h", m_tdata);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.byte_role !== want.byte_role) begin
						$error("byte_role: expected %0d, actual %0d", want.byte_role, got.byte_role);
						error_count++;
					end
					if (got.header_index !== want.header_index) begin
						$error("header_index: expected %0d, actual %0d",
							want.header_index, got.header_index);
						error_count++;
					end
					if (got.header_count !== want.header_count) begin
						$error("header_count: expected %0d, actual %0d",
							want.header_count, got.header_count);
						error_count++;
					end
					if (got.verdict !== want.verdict) begin
						$error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
						error_count++;
					end
					if (m_tdata[15:14] !== 2'b00) begin
						$error("pad: expected 0, actual %0d", m_tdata[15:14]);
						error_count++;
					end
					if (want.verdict == hrt_pkg::VERD_ACC) accept_seen++;
					if (want.verdict == hrt_pkg::VERD_REJ) reject_seen++;
				end
			end
			m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		model_phase = hrt_pkg::PH_METHOD;
		model_headers = '0;
		model_rejected = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles less than the receiver
		send_idle_pct = 28;
		recv_idle_pct = 57;
		test_directed_requests();
		test_header_limit();
		test_random_requests(RANDOM_BYTES);

		// receiver idles less than the sender
		send_idle_pct = 57;
		recv_idle_pct = 28;
		test_random_requests(RANDOM_BYTES);

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_requests(RANDOM_BYTES);

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("tokenized %0d bytes: %0d requests accepted, %0d rejected",
			bytes_sent, accept_seen, reject_seen);
		$display("three idling mixes plus one full drain pause per random pass");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
